@@ src/line_run_rasterizer_macros.svh @@
// Assertion macros for the line run rasterizer.
// Every use expects the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef LINE_RUN_RASTERIZER_MACROS_SVH
`define LINE_RUN_RASTERIZER_MACROS_SVH
`ifndef ASSERT_OFF
`define LRR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define LRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRR_ASSERT_ALWAYS(lbl, cond, msg)
`define LRR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/lrr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

    localparam int LRR_COORD_BITS     = 10;
    localparam int LRR_CFG_BITS       = 10;
    localparam int LRR_COLOR_BITS     = 16;
    localparam int LRR_QUEUE_DEPTH    = 2;
    localparam int LRR_CFG_INDEX_BITS = 1;

    // Configuration register indexes.
    localparam logic [LRR_CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [LRR_CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [LRR_CFG_BITS-1:0] SCREEN_WIDTH_RESET  = 10'd240;
    localparam logic [LRR_CFG_BITS-1:0] SCREEN_HEIGHT_RESET = 10'd320;

    // Request commands.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Classified request as it travels through the queue.
    typedef struct packed {
        logic cmd;
        logic steep;
        logic minor_down;
    } t_item_ctrl;

    // Flags that travel with a finished run.
    typedef struct packed {
        logic steep;
        logic last;
    } t_run_ctrl;

endpackage

`default_nettype wire

@@ src/lrr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrr_front
    import lrr_pkg::*;
#(
    parameter int COORD_BITS = LRR_COORD_BITS
) (
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_queue_full,
    output logic                           o_push,
    input  wire logic                      i_cmd,
    input  wire logic [COORD_BITS-1:0]     i_start_x,
    input  wire logic [COORD_BITS-1:0]     i_start_y,
    input  wire logic [COORD_BITS-1:0]     i_end_x,
    input  wire logic [COORD_BITS-1:0]     i_end_y,
    input  wire logic [LRR_COLOR_BITS-1:0] i_pixel_color,
    output t_item_ctrl                     o_ctrl,
    output logic [COORD_BITS-1:0]          o_major_start,
    output logic [COORD_BITS-1:0]          o_major_end,
    output logic [COORD_BITS-1:0]          o_minor_start,
    output logic [COORD_BITS-1:0]          o_delta_major,
    output logic [COORD_BITS-1:0]          o_delta_minor,
    output logic [LRR_COLOR_BITS-1:0]      o_color
);

    logic [COORD_BITS-1:0] w_dx;
    logic [COORD_BITS-1:0] w_dy;
    logic                  w_steep;
    logic [COORD_BITS-1:0] w_maj_a;
    logic [COORD_BITS-1:0] w_maj_b;
    logic [COORD_BITS-1:0] w_min_a;
    logic [COORD_BITS-1:0] w_min_b;
    logic                  w_swap;

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        w_dx    = (i_end_x >= i_start_x) ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
        w_dy    = (i_end_y >= i_start_y) ? (i_end_y - i_start_y) : (i_start_y - i_end_y);
        w_steep = w_dy > w_dx;
        w_maj_a = w_steep ? i_start_y : i_start_x;
        w_maj_b = w_steep ? i_end_y   : i_end_x;
        w_min_a = w_steep ? i_start_x : i_start_y;
        w_min_b = w_steep ? i_end_x   : i_end_y;
        // Order the ends so that the major coordinate climbs.
        w_swap  = w_maj_a > w_maj_b;

        o_major_start      = w_swap ? w_maj_b : w_maj_a;
        o_major_end        = w_swap ? w_maj_a : w_maj_b;
        o_minor_start      = w_swap ? w_min_b : w_min_a;
        o_delta_major      = w_steep ? w_dy : w_dx;
        o_delta_minor      = w_steep ? w_dx : w_dy;
        o_ctrl.cmd         = i_cmd;
        o_ctrl.steep       = w_steep;
        o_ctrl.minor_down  = w_swap ? (w_min_b < w_min_a) : (w_min_a < w_min_b);
        o_color            = i_pixel_color;
    end

endmodule

`default_nettype wire

@@ src/lrr_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrr_fifo
    import lrr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = LRR_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ src/lrr_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "line_run_rasterizer_macros.svh"

module lrr_step
    import lrr_pkg::*;
#(
    parameter int COORD_BITS = LRR_COORD_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_item_valid,
    output logic                           o_item_pop,
    input  wire t_item_ctrl                i_ctrl,
    input  wire logic [COORD_BITS-1:0]     i_major_start,
    input  wire logic [COORD_BITS-1:0]     i_major_end,
    input  wire logic [COORD_BITS-1:0]     i_minor_start,
    input  wire logic [COORD_BITS-1:0]     i_delta_major,
    input  wire logic [COORD_BITS-1:0]     i_delta_minor,
    input  wire logic [LRR_COLOR_BITS-1:0] i_color,
    output logic                           o_run_valid,
    input  wire logic                      i_run_ready,
    output logic [COORD_BITS-1:0]          o_run_x,
    output logic [COORD_BITS-1:0]          o_run_y,
    output logic [COORD_BITS:0]            o_run_len,
    output logic [LRR_COLOR_BITS-1:0]      o_run_color,
    output t_run_ctrl                      o_run_ctrl
);

    localparam int CNT_W = COORD_BITS + 1;
    localparam int ERR_W = COORD_BITS + 2;

    logic                       r_active,      n_active;
    logic                       r_steep,       n_steep;
    logic [COORD_BITS-1:0]      r_major_pos,   n_major_pos;
    logic [COORD_BITS-1:0]      r_major_end,   n_major_end;
    logic [COORD_BITS-1:0]      r_minor_pos,   n_minor_pos;
    logic                       r_minor_down,  n_minor_down;
    logic [COORD_BITS-1:0]      r_delta_major, n_delta_major;
    logic [COORD_BITS-1:0]      r_delta_minor, n_delta_minor;
    logic signed [ERR_W-1:0]    r_error,       n_error;
    logic [COORD_BITS-1:0]      r_run_start,   n_run_start;
    logic [CNT_W-1:0]           r_run_count,   n_run_count;
    logic [LRR_COLOR_BITS-1:0]  r_line_color,  n_line_color;

    logic                       r_run_valid,   n_run_valid;
    logic [COORD_BITS-1:0]      r_run_x;
    logic [COORD_BITS-1:0]      r_run_y;
    logic [CNT_W-1:0]           r_run_len;
    logic [LRR_COLOR_BITS-1:0]  r_run_color;
    t_run_ctrl                  r_run_ctrl;

    logic                       w_pop;
    logic                       w_start;
    logic                       w_step;
    logic                       w_final;
    logic [CNT_W-1:0]           w_count_inc;
    logic signed [ERR_W-1:0]    w_err_sub;
    logic                       w_err_neg;
    logic                       w_emit;

    always_comb begin
        w_pop       = i_item_valid && (!r_run_valid || i_run_ready);
        w_start     = w_pop && (i_ctrl.cmd == CMD_START);
        w_step      = w_pop && (i_ctrl.cmd == CMD_ADVANCE) && r_active;
        w_final     = r_major_pos == r_major_end;
        w_count_inc = r_run_count + CNT_W'(1);
        w_err_sub   = r_error - $signed({2'b00, r_delta_minor});
        w_err_neg   = w_err_sub[ERR_W-1];
        // The final step always hands out exactly one run.
        w_emit      = w_step && (w_err_neg || w_final);
    end

    always_comb begin
        n_active      = r_active;
        n_steep       = r_steep;
        n_major_pos   = r_major_pos;
        n_major_end   = r_major_end;
        n_minor_pos   = r_minor_pos;
        n_minor_down  = r_minor_down;
        n_delta_major = r_delta_major;
        n_delta_minor = r_delta_minor;
        n_error       = r_error;
        n_run_start   = r_run_start;
        n_run_count   = r_run_count;
        n_line_color  = r_line_color;
        if (w_start) begin
            n_active      = 1'b1;
            n_steep       = i_ctrl.steep;
            n_major_pos   = i_major_start;
            n_major_end   = i_major_end;
            n_minor_pos   = i_minor_start;
            n_minor_down  = i_ctrl.minor_down;
            n_delta_major = i_delta_major;
            n_delta_minor = i_delta_minor;
            n_error       = $signed({2'b00, i_delta_major >> 1});
            n_run_start   = i_major_start;
            n_run_count   = '0;
            n_line_color  = i_color;
        end else if (w_step) begin
            n_run_count = w_emit ? '0 : w_count_inc;
            if (w_err_neg) begin
                n_minor_pos = r_minor_down ? (r_minor_pos + COORD_BITS'(1))
                                           : (r_minor_pos - COORD_BITS'(1));
                n_run_start = r_major_pos + COORD_BITS'(1);
                n_error     = w_err_sub + $signed({2'b00, r_delta_major});
            end else begin
                n_error     = w_err_sub;
            end
            if (w_final) begin
                n_active = 1'b0;
            end else begin
                n_major_pos = r_major_pos + COORD_BITS'(1);
            end
        end
    end

    always_comb begin
        n_run_valid = w_emit || (r_run_valid && !i_run_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_steep       <= 1'b0;
            r_major_pos   <= '0;
            r_major_end   <= '0;
            r_minor_pos   <= '0;
            r_minor_down  <= 1'b0;
            r_delta_major <= '0;
            r_delta_minor <= '0;
            r_error       <= '0;
            r_run_start   <= '0;
            r_run_count   <= '0;
            r_line_color  <= '0;
            r_run_valid   <= 1'b0;
        end else begin
            r_active      <= n_active;
            r_steep       <= n_steep;
            r_major_pos   <= n_major_pos;
            r_major_end   <= n_major_end;
            r_minor_pos   <= n_minor_pos;
            r_minor_down  <= n_minor_down;
            r_delta_major <= n_delta_major;
            r_delta_minor <= n_delta_minor;
            r_error       <= n_error;
            r_run_start   <= n_run_start;
            r_run_count   <= n_run_count;
            r_line_color  <= n_line_color;
            r_run_valid   <= n_run_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_run_x          <= r_steep ? r_minor_pos : r_run_start;
            r_run_y          <= r_steep ? r_run_start : r_minor_pos;
            r_run_len        <= w_count_inc;
            r_run_color      <= r_line_color;
            r_run_ctrl.steep <= r_steep;
            r_run_ctrl.last  <= w_final;
        end
    end

    assign o_item_pop  = w_pop;
    assign o_run_valid = r_run_valid;
    assign o_run_x     = r_run_x;
    assign o_run_y     = r_run_y;
    assign o_run_len   = r_run_len;
    assign o_run_color = r_run_color;
    assign o_run_ctrl  = r_run_ctrl;

    `LRR_ASSERT_ALWAYS(a_major_within_line, !r_active || (r_major_pos <= r_major_end), "major position passed the line end")
    `LRR_ASSERT_ALWAYS(a_error_settled, !r_error[ERR_W-1], "error term left negative after a step")
    `LRR_ASSERT_NEXT(a_final_flushes, w_step && w_final, !r_active && r_run_valid && r_run_ctrl.last, "final step did not flush a last run")

endmodule

`default_nettype wire

@@ src/lrr_clip.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrr_clip
    import lrr_pkg::*;
#(
    parameter int COORD_BITS = LRR_COORD_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [LRR_CFG_BITS-1:0]   i_screen_width,
    input  wire logic [LRR_CFG_BITS-1:0]   i_screen_height,
    input  wire logic                      i_run_valid,
    output logic                           o_run_ready,
    input  wire logic [COORD_BITS-1:0]     i_run_x,
    input  wire logic [COORD_BITS-1:0]     i_run_y,
    input  wire logic [COORD_BITS:0]       i_run_len,
    input  wire logic [LRR_COLOR_BITS-1:0] i_run_color,
    input  wire t_run_ctrl                 i_run_ctrl,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [COORD_BITS-1:0]          o_run_x,
    output logic [COORD_BITS-1:0]          o_run_y,
    output logic [COORD_BITS:0]            o_run_length,
    output logic                           o_run_vertical,
    output logic [LRR_COLOR_BITS-1:0]      o_run_color,
    output logic                           o_visible,
    output logic                           o_last_run
);

    localparam int W = ((COORD_BITS > LRR_CFG_BITS) ? COORD_BITS : LRR_CFG_BITS) + 2;

    logic                      r_valid, n_valid;
    logic [COORD_BITS-1:0]     r_run_x;
    logic [COORD_BITS-1:0]     r_run_y;
    logic [COORD_BITS:0]       r_run_length;
    logic                      r_run_vertical;
    logic [LRR_COLOR_BITS-1:0] r_run_color;
    logic                      r_visible;
    logic                      r_last_run;

    logic                      w_take;
    logic [W-1:0]              w_x;
    logic [W-1:0]              w_y;
    logic [W-1:0]              w_width;
    logic [W-1:0]              w_height;
    logic [W-1:0]              w_along;
    logic [W-1:0]              w_limit;
    logic [W-1:0]              w_span_end;
    logic [W-1:0]              w_room;
    logic                      w_visible;
    logic [COORD_BITS:0]       w_length;

    always_comb begin
        w_take     = i_run_valid && (!r_valid || i_out_ready);
        w_x        = W'(i_run_x);
        w_y        = W'(i_run_y);
        w_width    = W'(i_screen_width);
        w_height   = W'(i_screen_height);
        w_along    = i_run_ctrl.steep ? w_y : w_x;
        w_limit    = i_run_ctrl.steep ? w_height : w_width;
        w_visible  = (w_x < w_width) && (w_y < w_height);
        w_span_end = w_along + W'(i_run_len);
        w_room     = w_limit - w_along;
        // A visible run that crosses the edge stops at it; a hidden one keeps its length.
        w_length   = (w_visible && (w_span_end > w_limit)) ? w_room[COORD_BITS:0] : i_run_len;
        n_valid    = w_take || (r_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_run_x        <= i_run_x;
            r_run_y        <= i_run_y;
            r_run_length   <= w_length;
            r_run_vertical <= i_run_ctrl.steep;
            r_run_color    <= i_run_color;
            r_visible      <= w_visible;
            r_last_run     <= i_run_ctrl.last;
        end
    end

    assign o_run_ready    = !r_valid || i_out_ready;
    assign o_out_valid    = r_valid;
    assign o_run_x        = r_run_x;
    assign o_run_y        = r_run_y;
    assign o_run_length   = r_run_length;
    assign o_run_vertical = r_run_vertical;
    assign o_run_color    = r_run_color;
    assign o_visible      = r_visible;
    assign o_last_run     = r_last_run;

endmodule

`default_nettype wire

@@ src/line_run_rasterizer.sv @@
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    i_cmd, i_start_x, i_start_y, i_end_x,
//                                                 i_end_y, i_pixel_color
// run       out        o_out_valid / i_out_ready  o_run_x, o_run_y, o_run_length,
//                                                 o_run_vertical, o_run_color, o_visible,
//                                                 o_last_run
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One request is taken every cycle while the two-entry queue has room, and the line stepper
// drains the queue at one request a cycle while no run waits on a stalled run port, so a steady
// stream runs at one request per cycle. A run leaves through the queue, the stepper register and
// the clipping register after its advance request. Reset is synchronous and active low; there is
// no clearing pass, so the block accepts requests as soon as reset is released.
// A stall on the run port holds the clipping register, then the stepper, then fills the queue.
`timescale 1ns / 1ps
`default_nettype none

module line_run_rasterizer
    import lrr_pkg::*;
#(
    parameter int COORD_BITS = LRR_COORD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port.
    input  wire logic                          i_cfg_we,
    input  wire logic [LRR_CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [LRR_CFG_BITS-1:0]       i_cfg_data,
    // Request channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_cmd,
    input  wire logic [COORD_BITS-1:0]         i_start_x,
    input  wire logic [COORD_BITS-1:0]         i_start_y,
    input  wire logic [COORD_BITS-1:0]         i_end_x,
    input  wire logic [COORD_BITS-1:0]         i_end_y,
    input  wire logic [LRR_COLOR_BITS-1:0]     i_pixel_color,
    // Run channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [COORD_BITS-1:0]              o_run_x,
    output logic [COORD_BITS-1:0]              o_run_y,
    output logic [COORD_BITS:0]                o_run_length,
    output logic                               o_run_vertical,
    output logic [LRR_COLOR_BITS-1:0]          o_run_color,
    output logic                               o_visible,
    output logic                               o_last_run
);

    // A queued request carries its classification, the ordered line set-up and its colour.
    localparam int ITEM_W = $bits(t_item_ctrl) + 5 * COORD_BITS + LRR_COLOR_BITS;

    // The user must write the screen size registers only while the block is idle; the block does not enforce it.
    logic [LRR_CFG_BITS-1:0]   r_screen_width,  n_screen_width;
    logic [LRR_CFG_BITS-1:0]   r_screen_height, n_screen_height;

    logic                      w_push;
    logic                      w_queue_full;
    logic                      w_queue_valid;
    logic                      w_queue_pop;
    logic [ITEM_W-1:0]         w_queue_wdata;
    logic [ITEM_W-1:0]         w_queue_rdata;

    t_item_ctrl                w_f_ctrl;
    logic [COORD_BITS-1:0]     w_f_major_start;
    logic [COORD_BITS-1:0]     w_f_major_end;
    logic [COORD_BITS-1:0]     w_f_minor_start;
    logic [COORD_BITS-1:0]     w_f_delta_major;
    logic [COORD_BITS-1:0]     w_f_delta_minor;
    logic [LRR_COLOR_BITS-1:0] w_f_color;

    t_item_ctrl                w_b_ctrl;
    logic [COORD_BITS-1:0]     w_b_major_start;
    logic [COORD_BITS-1:0]     w_b_major_end;
    logic [COORD_BITS-1:0]     w_b_minor_start;
    logic [COORD_BITS-1:0]     w_b_delta_major;
    logic [COORD_BITS-1:0]     w_b_delta_minor;
    logic [LRR_COLOR_BITS-1:0] w_b_color;

    logic                      w_run_valid;
    logic                      w_run_ready;
    logic [COORD_BITS-1:0]     w_run_x;
    logic [COORD_BITS-1:0]     w_run_y;
    logic [COORD_BITS:0]       w_run_len;
    logic [LRR_COLOR_BITS-1:0] w_run_color;
    t_run_ctrl                 w_run_ctrl;

    always_comb begin
        n_screen_width  = r_screen_width;
        n_screen_height = r_screen_height;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH: begin
                    n_screen_width = i_cfg_data;
                end
                CFG_SCREEN_HEIGHT: begin
                    n_screen_height = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RESET;
            r_screen_height <= SCREEN_HEIGHT_RESET;
        end else begin
            r_screen_width  <= n_screen_width;
            r_screen_height <= n_screen_height;
        end
    end

    // The front end classifies each request and works out the octant set-up for a start,
    // so the stepper only has to load it.
    lrr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_queue_full  (w_queue_full),
        .o_push        (w_push),
        .i_cmd         (i_cmd),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_pixel_color (i_pixel_color),
        .o_ctrl        (w_f_ctrl),
        .o_major_start (w_f_major_start),
        .o_major_end   (w_f_major_end),
        .o_minor_start (w_f_minor_start),
        .o_delta_major (w_f_delta_major),
        .o_delta_minor (w_f_delta_minor),
        .o_color       (w_f_color)
    );

    assign w_queue_wdata = {w_f_ctrl, w_f_major_start, w_f_major_end, w_f_minor_start,
                            w_f_delta_major, w_f_delta_minor, w_f_color};

    lrr_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (LRR_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_queue_wdata),
        .o_full  (w_queue_full),
        .o_valid (w_queue_valid),
        .i_pop   (w_queue_pop),
        .o_data  (w_queue_rdata)
    );

    assign {w_b_ctrl, w_b_major_start, w_b_major_end, w_b_minor_start,
            w_b_delta_major, w_b_delta_minor, w_b_color} = w_queue_rdata;

    // The stepper runs Bresenham's error update, one major-axis step per advance request,
    // and hands each finished run to the clipping stage.
    lrr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_queue_valid),
        .o_item_pop    (w_queue_pop),
        .i_ctrl        (w_b_ctrl),
        .i_major_start (w_b_major_start),
        .i_major_end   (w_b_major_end),
        .i_minor_start (w_b_minor_start),
        .i_delta_major (w_b_delta_major),
        .i_delta_minor (w_b_delta_minor),
        .i_color       (w_b_color),
        .o_run_valid   (w_run_valid),
        .i_run_ready   (w_run_ready),
        .o_run_x       (w_run_x),
        .o_run_y       (w_run_y),
        .o_run_len     (w_run_len),
        .o_run_color   (w_run_color),
        .o_run_ctrl    (w_run_ctrl)
    );

    // The clipping stage checks the run start against the screen and cuts the length at
    // the edge; its register is the output register of the run channel.
    lrr_clip #(
        .COORD_BITS (COORD_BITS)
    ) u_clip (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_run_valid     (w_run_valid),
        .o_run_ready     (w_run_ready),
        .i_run_x         (w_run_x),
        .i_run_y         (w_run_y),
        .i_run_len       (w_run_len),
        .i_run_color     (w_run_color),
        .i_run_ctrl      (w_run_ctrl),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_run_x         (o_run_x),
        .o_run_y         (o_run_y),
        .o_run_length    (o_run_length),
        .o_run_vertical  (o_run_vertical),
        .o_run_color     (o_run_color),
        .o_visible       (o_visible),
        .o_last_run      (o_last_run)
    );

endmodule

`default_nettype wire

@@ sim/line_run_rasterizer_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the line run rasterizer.
//
// A scoreboard object keeps its own copy of the line stepper: every request that the block
// accepts is replayed on it, and the runs that the request ought to produce are queued.
// Every run that leaves the block is then compared, field by field, with the oldest queued
// run. The stimulus opens with a short hand-written list (advance while idle, a single-pixel
// line, ordering of the ends, a steep line, a line abandoned by a new start, clipping at the
// right-hand edge). After that it runs eight phases, each with its own screen size and one
// of four patterns of idling on the two channels, made mostly of complete random lines often
// placed close to the screen edges, plus lines cut short and fully random start requests.
module line_run_rasterizer_test;
    import lrr_pkg::*;

    localparam int COORD_W = LRR_COORD_BITS;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    // Generous ceiling on the whole run.
    localparam int CYCLE_LIMIT = 400000;

    // One run as it appears on the output channel.
    typedef struct packed {
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
        logic [COORD_W:0]          length;
        logic                      vertical;
        logic [LRR_COLOR_BITS-1:0] color;
        logic                      visible;
        logic                      last;
    } run_t;

    // The scoreboard mirrors the stepper state and holds the runs still owed by the block.
    class run_scoreboard;
        int                        screen_w;
        int                        screen_h;
        bit                        active;
        bit                        steep;
        bit                        minor_down;
        logic [COORD_W-1:0]        major_pos;
        logic [COORD_W-1:0]        major_end;
        logic [COORD_W-1:0]        minor_pos;
        logic [COORD_W-1:0]        run_start;
        logic [COORD_W:0]          run_count;
        logic [LRR_COLOR_BITS-1:0] line_color;
        int                        delta_major;
        int                        delta_minor;
        int                        err;
        run_t                      runs_due[$];
        int                        errors;
        int                        checked;
        int                        clipped;
        int                        off_screen;
        int                        vertical;

        function new();
            screen_w    = int'(SCREEN_WIDTH_RESET);
            screen_h    = int'(SCREEN_HEIGHT_RESET);
            active      = 1'b0;
            steep       = 1'b0;
            minor_down  = 1'b0;
            major_pos   = '0;
            major_end   = '0;
            minor_pos   = '0;
            run_start   = '0;
            run_count   = '0;
            line_color  = '0;
            delta_major = 0;
            delta_minor = 0;
            err         = 0;
            errors      = 0;
            checked     = 0;
            clipped     = 0;
            off_screen  = 0;
            vertical    = 0;
        endfunction

        // Builds the run that is finished now, clipped against the current screen size.
        function run_t clip_run(bit last);
            run_t r;
            int   px, py, along, lim, len;
            bit   vis;
            len = int'(run_count);
            if (steep) begin
                px    = int'(minor_pos);
                py    = int'(run_start);
                along = py;
                lim   = screen_h;
            end else begin
                px    = int'(run_start);
                py    = int'(minor_pos);
                along = px;
                lim   = screen_w;
            end
            vis = (px < screen_w) && (py < screen_h);
            if (vis && along + len - 1 >= lim) begin
                len = lim - along;
                clipped++;
            end
            if (!vis)
                off_screen++;
            if (steep)
                vertical++;
            r.x        = px[COORD_W-1:0];
            r.y        = py[COORD_W-1:0];
            r.length   = len[COORD_W:0];
            r.vertical = steep;
            r.color    = line_color;
            r.visible  = vis;
            r.last     = last;
            return r;
        endfunction

        // Replays one accepted request and queues the runs that it produces.
        function void note_request(logic cmd, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                   logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                                   logic [LRR_COLOR_BITS-1:0] col);
            int ax, ay, bx, by, dx, dy, t;
            bit final_step;
            if (cmd == CMD_START) begin
                ax = int'(sx);
                ay = int'(sy);
                bx = int'(ex);
                by = int'(ey);
                dx = (bx > ax) ? bx - ax : ax - bx;
                dy = (by > ay) ? by - ay : ay - by;
                steep = dy > dx;
                if (steep) begin
                    t = ax; ax = ay; ay = t;
                    t = bx; bx = by; by = t;
                end
                if (ax > bx) begin
                    t = ax; ax = bx; bx = t;
                    t = ay; ay = by; by = t;
                end
                delta_major = bx - ax;
                delta_minor = (by > ay) ? by - ay : ay - by;
                err         = delta_major >> 1;
                minor_down  = ay < by;
                major_pos   = ax[COORD_W-1:0];
                major_end   = bx[COORD_W-1:0];
                minor_pos   = ay[COORD_W-1:0];
                run_start   = ax[COORD_W-1:0];
                run_count   = '0;
                line_color  = col;
                active      = 1'b1;
                return;
            end
            if (!active)
                return;
            final_step = (major_pos == major_end);
            run_count  = run_count + 1'b1;
            err        = err - delta_minor;
            if (err < 0) begin
                runs_due.push_back(clip_run(final_step));
                run_count = '0;
                minor_pos = minor_down ? minor_pos + 1'b1 : minor_pos - 1'b1;
                run_start = major_pos + 1'b1;
                err       = err + delta_major;
            end
            if (final_step) begin
                if (run_count != 0)
                    runs_due.push_back(clip_run(1'b1));
                active    = 1'b0;
                run_count = '0;
            end else begin
                major_pos = major_pos + 1'b1;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_run(run_t got);
            run_t want;
            if (runs_due.size() == 0) begin
                report($sformatf("run at (%0d,%0d) with no run due", got.x, got.y));
                return;
            end
            want = runs_due.pop_front();
            checked++;
            if (got.x !== want.x)
                report($sformatf("run_x %0d, expected %0d", got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("run_y %0d, expected %0d", got.y, want.y));
            if (got.length !== want.length)
                report($sformatf("run_length %0d, expected %0d", got.length, want.length));
            if (got.vertical !== want.vertical)
                report($sformatf("run_vertical %0b, expected %0b", got.vertical,
                                 want.vertical));
            if (got.color !== want.color)
                report($sformatf("run_color %h, expected %h", got.color, want.color));
            if (got.visible !== want.visible)
                report($sformatf("visible %0b, expected %0b", got.visible, want.visible));
            if (got.last !== want.last)
                report($sformatf("last_run %0b, expected %0b", got.last, want.last));
        endtask
    endclass

    // Every input of the block starts from a known value.
    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic [LRR_CFG_INDEX_BITS-1:0] i_cfg_index = CFG_SCREEN_WIDTH;
    logic [LRR_CFG_BITS-1:0]     i_cfg_data    = '0;
    logic                        i_in_valid    = 1'b0;
    logic                        i_cmd         = CMD_START;
    logic [COORD_W-1:0]          i_start_x     = '0;
    logic [COORD_W-1:0]          i_start_y     = '0;
    logic [COORD_W-1:0]          i_end_x       = '0;
    logic [COORD_W-1:0]          i_end_y       = '0;
    logic [LRR_COLOR_BITS-1:0]   i_pixel_color = '0;
    logic                        i_out_ready   = 1'b0;

    logic                        o_in_ready;
    logic                        o_out_valid;
    logic [COORD_W-1:0]          o_run_x;
    logic [COORD_W-1:0]          o_run_y;
    logic [COORD_W:0]            o_run_length;
    logic                        o_run_vertical;
    logic [LRR_COLOR_BITS-1:0]   o_run_color;
    logic                        o_visible;
    logic                        o_last_run;

    run_scoreboard sb = new();

    // Idling odds in percent, changed from phase to phase.
    int send_idle     = 0;
    int recv_stall    = 0;
    int requests_sent = 0;
    int cycles        = 0;

    line_run_rasterizer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_pixel_color  (i_pixel_color),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_run_x        (o_run_x),
        .o_run_y        (o_run_y),
        .o_run_length   (o_run_length),
        .o_run_vertical (o_run_vertical),
        .o_run_color    (o_run_color),
        .o_visible      (o_visible),
        .o_last_run     (o_last_run)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d runs still due", cycles,
                     sb.runs_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Run channel: outputs are sampled at the rising edge, before the block updates them,
    // and ready is redrawn every cycle according to the stall odds of the phase.
    always @(posedge i_clk) begin : run_monitor
        run_t seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.x        = o_run_x;
            seen.y        = o_run_y;
            seen.length   = o_run_length;
            seen.vertical = o_run_vertical;
            seen.color    = o_run_color;
            seen.visible  = o_visible;
            seen.last     = o_last_run;
            sb.check_run(seen);
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // Presents one request, holds it until the block takes it, then tells the scoreboard.
    // Valid is only lowered for a gap, so it never drops and rises in one time step.
    task automatic put_request(logic cmd, int sx, int sy, int ex, int ey, int col);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_start_x     <= COORD_W'(sx);
        i_start_y     <= COORD_W'(sy);
        i_end_x       <= COORD_W'(ex);
        i_end_y       <= COORD_W'(ey);
        i_pixel_color <= LRR_COLOR_BITS'(col);
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_request(cmd, COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey),
                        LRR_COLOR_BITS'(col));
        requests_sent++;
    endtask

    // An advance ignores the payload, so the coordinate fields carry noise.
    task automatic advance();
        put_request(CMD_ADVANCE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, 65535));
    endtask

    // Stops sending, waits for every run still due, then lets the pipeline empty out,
    // since start requests and ignored advances leave no run to wait for.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.runs_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_screen(int w, int h);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= LRR_CFG_BITS'(w);
        @(posedge i_clk);
        i_cfg_index <= CFG_SCREEN_HEIGHT;
        i_cfg_data  <= LRR_CFG_BITS'(h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.screen_w = w;
        sb.screen_h = h;
    endtask

    // Picks the lower end of a span of length d, half the time close to a screen edge
    // so that clipping and runs starting just off screen are common.
    function automatic int place(int edge_pos, int d);
        int v;
        if ($urandom_range(0, 1))
            return $urandom_range(0, COORD_MAX - d);
        v = edge_pos - d - 4 + $urandom_range(0, d + 8);
        if (v < 0)
            v = 0;
        if (v > COORD_MAX - d)
            v = COORD_MAX - d;
        return v;
    endfunction

    // One random line: mostly complete and short, some cut short by the next start, some
    // followed by advances that the idle stepper must ignore, and a few fully random starts.
    task automatic draw_sequence();
        int kind, span, dmin, dx, dy, x0, y0, x1, y1, t, n;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            put_request(CMD_START, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, 65535));
            n = $urandom_range(0, 3);
        end else begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 120) : $urandom_range(0, 20);
            case ($urandom_range(0, 3))
                0:       dmin = 0;
                1:       dmin = span;
                default: dmin = $urandom_range(0, span);
            endcase
            if ($urandom_range(0, 1)) begin
                dx = dmin;
                dy = span;
            end else begin
                dx = span;
                dy = dmin;
            end
            x0 = place(sb.screen_w, dx);
            y0 = place(sb.screen_h, dy);
            x1 = x0 + dx;
            y1 = y0 + dy;
            if ($urandom_range(0, 1)) begin
                t = x0; x0 = x1; x1 = t;
            end
            if ($urandom_range(0, 1)) begin
                t = y0; y0 = y1; y1 = t;
            end
            put_request(CMD_START, x0, y0, x1, y1, $urandom_range(0, 65535));
            n = span + 1;
            if (kind < 24)
                n = $urandom_range(0, span);
            else if ($urandom_range(0, 4) == 0)
                n = n + $urandom_range(1, 2);
        end
        repeat (n) advance();
    endtask

    initial begin : stimulus
        int p, w, h, target;
        bit paused;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hand-written opening, at the reset screen size and with no idling.
        // An advance with no line loaded is dropped.
        advance();
        // Single pixel at the far corner: one run, off screen.
        put_request(CMD_START, 1023, 1023, 1023, 1023, 16'hFFFF);
        advance();
        // Flat line given right to left, crossing the right-hand edge: cut to four pixels.
        put_request(CMD_START, 241, 0, 236, 0, 16'h0000);
        repeat (6) advance();
        // Steep line: two vertical runs of two pixels each.
        put_request(CMD_START, 0, 0, 1, 3, 16'hA5A5);
        repeat (4) advance();
        // A long diagonal abandoned after two steps by a new start, then a short 45 degree
        // line, then one more advance after its end which must be dropped.
        put_request(CMD_START, 0, 1023, 1023, 0, 16'h5A5A);
        repeat (2) advance();
        put_request(CMD_START, 2, 2, 0, 0, 16'h0F0F);
        repeat (4) advance();

        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin w = 1023; h = 1023; end
                1: begin w = 1;    h = 1;    end
                2: begin w = 240;  h = 320;  end
                3: begin w = 0;    h = 700;  end
                4: begin w = 700;  h = 0;    end
                7: begin w = 320;  h = 240;  end
                default: begin
                    w = $urandom_range(1, 1023);
                    h = $urandom_range(1, 1023);
                end
            endcase
            set_screen(w, h);
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 65; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 65; end
                default: begin send_idle = 13; recv_stall = 13; end
            endcase
            if (p == 0) begin
                // Longest possible line along the bottom row, which lies just off screen:
                // one run whose unclipped length is the full 1024 pixels.
                put_request(CMD_START, 0, 1023, 1023, 1023, 16'h1234);
                repeat (1024) advance();
            end
            target = requests_sent + 40;
            paused = 1'b0;
            while (requests_sent < target) begin
                draw_sequence();
                // Midway through each phase the sender holds off until the block is empty.
                if (!paused && requests_sent > target - 20) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        $display("Sent %0d requests across eight screen sizes, zero and one among them,",
                 requests_sent);
        $display("under four idling patterns; %0d runs checked, %0d clipped,",
                 sb.checked, sb.clipped);
        $display("%0d off screen, %0d vertical.", sb.off_screen, sb.vertical);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
